>>> hdl/gllp_pkg.sv
// Shared constants, types and lookup tables for the Gaussian label log potential block.
package gllp_pkg;

  localparam int COLORS = 5;
  localparam int CW     = (COLORS > 1) ? $clog2(COLORS) : 1;
  localparam int ZW     = 21;

  localparam logic [15:0] INV_RESET = 16'd512;
  localparam logic [17:0] LN2_Q16   = 18'd45426;
  localparam logic [20:0] SAT_MAG   = 21'd65536;
  localparam logic [11:0] EXP_CUT   = 12'd12;

  typedef logic [19:0] mag_t;
  typedef logic [16:0] q16_t;
  typedef logic [9:0]  logz_t;

  localparam logic [16:0] EXP_INT [12] = '{
    17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442,
    17'd162, 17'd60, 17'd22, 17'd8, 17'd3, 17'd1
  };
  localparam logic [16:0] EXP_HI [16] = '{
    17'd65536, 17'd61565, 17'd57835, 17'd54331, 17'd51039, 17'd47947, 17'd45042, 17'd42313,
    17'd39750, 17'd37341, 17'd35079, 17'd32954, 17'd30957, 17'd29081, 17'd27319, 17'd25664
  };
  localparam logic [16:0] EXP_LO [16] = '{
    17'd65536, 17'd65280, 17'd65026, 17'd64772, 17'd64520, 17'd64268, 17'd64018, 17'd63768,
    17'd63520, 17'd63272, 17'd63025, 17'd62780, 17'd62535, 17'd62291, 17'd62048, 17'd61806
  };
  localparam logic [15:0] LN_TAB [17] = '{
    16'd0, 16'd3973, 16'd7719, 16'd11262, 16'd14624, 16'd17821, 16'd20870, 16'd23783,
    16'd26573, 16'd29248, 16'd31818, 16'd34292, 16'd36675, 16'd38975, 16'd41196, 16'd43346,
    16'd45426
  };

endpackage

>>> hdl/gllp_potential.sv
// Per-label Gaussian potential magnitudes and shift by the minimum, four stages.
module gllp_potential (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       en,
  input  logic                                       in_valid,
  input  logic [11:0]                                obs,
  input  logic [15:0]                                inv,
  output logic                                       out_valid,
  output gllp_pkg::mag_t [gllp_pkg::COLORS-1:0]      d
);

  logic                                   v1, v2, v3;
  logic [23:0]                            sq [gllp_pkg::COLORS];
  gllp_pkg::mag_t                         mag2 [gllp_pkg::COLORS];
  gllp_pkg::mag_t                         mag3 [gllp_pkg::COLORS];
  gllp_pkg::mag_t                         min3;
  logic [23:0]                            sq_next [gllp_pkg::COLORS];
  gllp_pkg::mag_t                         mag_next [gllp_pkg::COLORS];
  gllp_pkg::mag_t                         min_next;

  // Square the distance to each label
  always_comb begin
    logic [11:0] lab;
    logic [11:0] diff;
    for (int n = 0; n < gllp_pkg::COLORS; n++) begin
      lab  = 12'(n * 256);
      diff = (obs >= lab) ? obs - lab : lab - obs;
      sq_next[n] = {12'd0, diff} * {12'd0, diff};
    end
  end

  // Scale by the register and round half up to Q12.8
  always_comb begin
    logic [39:0] prod;
    for (int n = 0; n < gllp_pkg::COLORS; n++) begin
      prod = {16'd0, sq[n]} * {24'd0, inv} + 40'd524288;
      mag_next[n] = prod[39:20];
    end
  end

  // Find the smallest magnitude
  always_comb begin
    min_next = mag2[0];
    for (int n = 1; n < gllp_pkg::COLORS; n++) begin
      if (mag2[n] < min_next) min_next = mag2[n];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
    if (en) begin
      sq   <= sq_next;
      mag2 <= mag_next;
      mag3 <= mag2;
      min3 <= min_next;
      for (int n = 0; n < gllp_pkg::COLORS; n++) d[n] <= mag3[n] - min3;
    end
  end

endmodule

>>> hdl/gllp_norm.sv
// Table exponential, sum over labels and table logarithm, six stages.
module gllp_norm (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  gllp_pkg::mag_t [gllp_pkg::COLORS-1:0]  d_in,
  output logic                                   out_valid,
  output gllp_pkg::mag_t [gllp_pkg::COLORS-1:0]  d_out,
  output gllp_pkg::logz_t                        logz
);

  logic [5:0]                            v;
  gllp_pkg::mag_t [gllp_pkg::COLORS-1:0] dp [5];
  gllp_pkg::q16_t                        t [gllp_pkg::COLORS];
  logic [3:0]                            lo [gllp_pkg::COLORS];
  gllp_pkg::q16_t                        e [gllp_pkg::COLORS];
  logic [gllp_pkg::ZW-1:0]               z;
  logic [2:0]                            k4, k5;
  logic [15:0]                           f;
  logic [15:0]                           ln;
  gllp_pkg::q16_t                        t_next [gllp_pkg::COLORS];
  gllp_pkg::q16_t                        e_next [gllp_pkg::COLORS];
  logic [gllp_pkg::ZW-1:0]               z_next;
  logic [2:0]                            k_next;
  logic [gllp_pkg::ZW-1:0]               m_next;
  logic [15:0]                           ln_next;
  logic [17:0]                           total;

  // Coarse exponential from the integer and high fraction bits
  always_comb begin
    logic [33:0] p;
    logic [11:0] a;
    for (int n = 0; n < gllp_pkg::COLORS; n++) begin
      a = d_in[n][19:8];
      p = {17'd0, gllp_pkg::EXP_INT[a[3:0]]} * {17'd0, gllp_pkg::EXP_HI[d_in[n][7:4]]}
          + 34'd32768;
      t_next[n] = (a >= gllp_pkg::EXP_CUT) ? 17'd0 : p[32:16];
    end
  end

  // Refine with the low fraction bits
  always_comb begin
    logic [33:0] p;
    for (int n = 0; n < gllp_pkg::COLORS; n++) begin
      p = {17'd0, t[n]} * {17'd0, gllp_pkg::EXP_LO[lo[n]]} + 34'd32768;
      e_next[n] = p[32:16];
    end
  end

  // Sum over labels
  always_comb begin
    z_next = '0;
    for (int n = 0; n < gllp_pkg::COLORS; n++) z_next = z_next + gllp_pkg::ZW'(e[n]);
  end

  // Normalize the sum into [1,2)
  always_comb begin
    if (z[20])      k_next = 3'd4;
    else if (z[19]) k_next = 3'd3;
    else if (z[18]) k_next = 3'd2;
    else if (z[17]) k_next = 3'd1;
    else            k_next = 3'd0;
    m_next = z >> k_next;
  end

  // Interpolate the log table
  always_comb begin
    logic [3:0]  i;
    logic [11:0] r;
    logic [15:0] step;
    logic [27:0] p;
    i    = f[15:12];
    r    = f[11:0];
    step = gllp_pkg::LN_TAB[5'(i) + 5'd1] - gllp_pkg::LN_TAB[i];
    p    = {12'd0, step} * {16'd0, r} + 28'd2048;
    ln_next = gllp_pkg::LN_TAB[i] + p[27:12];
  end

  always_comb begin
    logic [20:0] kl;
    kl    = 21'(k5) * 21'(gllp_pkg::LN2_Q16);
    total = kl[17:0] + {2'd0, ln} + 18'd128;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v         <= {v[4:0], in_valid};
      out_valid <= v[4];
    end
    if (en) begin
      dp[0] <= d_in;
      for (int s = 1; s < 5; s++) dp[s] <= dp[s-1];
      d_out <= dp[4];
      t     <= t_next;
      for (int n = 0; n < gllp_pkg::COLORS; n++) lo[n] <= d_in[n][3:0];
      e     <= e_next;
      z     <= z_next;
      k4    <= k_next;
      f     <= m_next[15:0];
      k5    <= k4;
      ln    <= ln_next;
      logz  <= total[17:8];
    end
  end

endmodule

>>> hdl/gllp_serial.sv
// Output register that emits one beat per label for each finished pixel.
module gllp_serial (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   load,
  input  gllp_pkg::mag_t [gllp_pkg::COLORS-1:0]  d_in,
  input  gllp_pkg::logz_t                        logz_in,
  output logic                                   free,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [3:0]                             label,
  output logic signed [16:0]                     log_prob,
  output logic                                   last
);

  gllp_pkg::mag_t [gllp_pkg::COLORS-1:0] d;
  gllp_pkg::logz_t                       logz;
  logic [gllp_pkg::CW-1:0]               cnt;
  logic [20:0]                           neg;

  assign last  = (cnt == gllp_pkg::CW'(gllp_pkg::COLORS - 1));
  assign label = 4'(cnt);
  assign free  = !out_valid || (!out_stall && last);

  // Add the log normalizer and saturate
  always_comb begin
    neg      = {1'b0, d[cnt]} + 21'(logz);
    log_prob = (neg > gllp_pkg::SAT_MAG) ? 17'h10000 : 17'(17'd0 - neg[16:0]);
  end

  // Advance one label per accepted beat, reload when empty or at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      cnt       <= '0;
    end else if (out_valid && !out_stall) begin
      if (last) out_valid <= 1'b0;
      cnt <= last ? '0 : cnt + 1'b1;
    end
    if (load) begin
      d    <= d_in;
      logz <= logz_in;
    end
  end

endmodule

>>> hdl/gllp_top_dummy_unused.sv
// Configuration register for the inverse two sigma squared scale.
module gllp_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [15:0] wr_data,
  output logic [15:0] inv
);

  // Hold the scale, take a new one on each write
  always_ff @(posedge clk) begin
    if (rst) inv <= gllp_pkg::INV_RESET;
    else if (wr_en) inv <= wr_data;
  end

endmodule

>>> hdl/gaussian_label_log_potential.sv
// Top level of the Gaussian label log potential block.
//
//  port group   dir  handshake            payload
//  in           in   in_valid/in_stall    obs[11:0]
//  out          out  out_valid/out_stall  label[3:0], log_prob[16:0], last
//  config       in   wr_en                wr_data[15:0]
//
// A pixel passes 10 pipeline stages and then the output register. Each pixel
// emits COLORS beats, one per cycle while out_stall is low; the output beats
// set the sustained pixel rate. Reset is synchronous and loads the scale with
// sigma two. A stall on the output, or any beat before the last one, freezes the
// whole pipeline once the result register still holds beats and a new pixel is
// ready.
module gaussian_label_log_potential (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        obs,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         label,
  output logic signed [16:0] log_prob,
  output logic               last,
  input  logic               wr_en,
  input  logic [15:0]        wr_data
);

  logic                                  en;
  logic                                  free;
  logic                                  pot_valid;
  logic                                  norm_valid;
  logic [15:0]                           inv;
  gllp_pkg::mag_t [gllp_pkg::COLORS-1:0] d_pot;
  gllp_pkg::mag_t [gllp_pkg::COLORS-1:0] d_norm;
  gllp_pkg::logz_t                       logz;

  // Advance the pipeline unless a finished pixel waits on a busy output
  assign en       = !norm_valid || free;
  assign in_stall = !en;

  gllp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .inv     (inv)
  );

  gllp_potential u_pot (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .obs       (obs),
    .inv       (inv),
    .out_valid (pot_valid),
    .d         (d_pot)
  );

  gllp_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pot_valid),
    .d_in      (d_pot),
    .out_valid (norm_valid),
    .d_out     (d_norm),
    .logz      (logz)
  );

  gllp_serial u_ser (
    .clk       (clk),
    .rst       (rst),
    .load      (norm_valid && free),
    .d_in      (d_norm),
    .logz_in   (logz),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .label     (label),
    .log_prob  (log_prob),
    .last      (last)
  );

  // An empty output register never backs up the pipeline
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall) else $error("input stalled with empty output");

  // Labels step by one inside a pixel
  a_label_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid && label == $past(label) + 4'd1)
    else $error("label sequence broken");

  // Log probabilities are never positive
  a_nonpositive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (log_prob[16] || log_prob == 17'sd0))
    else $error("positive log probability");

endmodule
